@@ hw/rtl/tlft_pkg.sv @@
// Shared types and character codes for the tab line field tokenizer.
package tlft_pkg;

	// Character codes the tokenizer reacts to.
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_EQ  = 8'h3D;
	localparam logic [7:0] CH_AT  = 8'h40;
	localparam logic [7:0] CH_A   = 8'h41;
	localparam logic [7:0] CH_Z   = 8'h5A;

	// Event kinds.
	localparam logic EV_FIELD  = 1'b0;
	localparam logic EV_STATUS = 1'b1;

	// Field classes.
	localparam logic [1:0] CLS_KIND    = 2'd0;
	localparam logic [1:0] CLS_SUBJECT = 2'd1;
	localparam logic [1:0] CLS_ATTR    = 2'd2;

	// Line status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_KIND  = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	// Depth of the result queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic       event_kind;
		logic [1:0] field_class;
		logic [3:0] field_slot;
		logic [9:0] field_start;
		logic [9:0] field_length;
		logic [9:0] key_length;
		logic       is_command;
		logic [1:0] line_status;
		logic       last;
	} tlft_result_t;

	// Up to two results produced by one byte, first one in slot a.
	typedef struct packed {
		logic         a_valid;
		tlft_result_t a;
		logic         b_valid;
		tlft_result_t b;
	} tlft_push_t;

endpackage

@@ hw/rtl/tlft_if.sv @@
// Valid/ready channel interfaces for the byte stream and the token results.
interface tlft_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface tlft_token_if;
	logic       valid;
	logic       ready;
	logic       event_kind;
	logic [1:0] field_class;
	logic [3:0] field_slot;
	logic [9:0] field_start;
	logic [9:0] field_length;
	logic [9:0] key_length;
	logic       is_command;
	logic [1:0] line_status;
	logic       last;

	modport source (output valid, output event_kind, output field_class, output field_slot,
		output field_start, output field_length, output key_length, output is_command,
		output line_status, output last, input ready);
	modport sink (input valid, input event_kind, input field_class, input field_slot,
		input field_start, input field_length, input key_length, input is_command,
		input line_status, input last, output ready);
endinterface

@@ hw/rtl/tlft_front.sv @@
// Front end: accepts bytes, tracks line and field state, classifies closed fields.
module tlft_front import tlft_pkg::*; #(
	parameter int LINE_MAX_BYTES = 1024,
	parameter int MAX_FIELDS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	tlft_stream_if.sink   stream,
	input  logic          room,
	output tlft_push_t    push
);

	localparam int POS_W = $clog2(LINE_MAX_BYTES);
	localparam int CNT_W = $clog2(MAX_FIELDS + 1);

	logic [POS_W-1:0] line_pos_q;
	logic [POS_W-1:0] field_begin_q;
	logic [POS_W-1:0] eq_offset_q;
	logic             eq_seen_q;
	logic [7:0]       first_byte_q;
	logic             kind_found_q;
	logic [CNT_W-1:0] subj_count_q;
	logic [CNT_W-1:0] attr_count_q;
	logic             skipping_q;
	logic             nul_seen_q;
	logic             prev_cr_q;

	logic             accept;
	logic [7:0]       b;
	logic             is_lf, is_nul, is_tab;
	logic             overlong;
	logic             closing;
	logic             line_end;
	logic [POS_W-1:0] raw_len;
	logic [POS_W-1:0] len;
	logic             has_key;
	logic             cls_kind, cls_attr, cls_subj;
	logic             emit_field;
	logic             emit_status;
	tlft_result_t     desc;
	tlft_result_t     status;

	assign accept = stream.valid & room;
	assign stream.ready = room;
	assign b = stream.data_byte;

	always_comb begin
		is_lf  = (b == CH_LF);
		is_nul = (b == CH_NUL);
		is_tab = (b == CH_TAB);
		overlong = !is_lf && !skipping_q &&
			(({1'b0, line_pos_q} + (POS_W+1)'(1)) >= (POS_W+1)'(LINE_MAX_BYTES));
		closing = !skipping_q && !nul_seen_q && (is_lf || (!overlong && (is_nul || is_tab)));
		line_end = is_lf || is_nul;
		raw_len = (line_pos_q >= field_begin_q) ? line_pos_q - field_begin_q : '0;
		len = (line_end && prev_cr_q && raw_len != '0) ? raw_len - POS_W'(1) : raw_len;
		has_key = eq_seen_q && (eq_offset_q != '0);
		cls_kind = !kind_found_q && (first_byte_q != CH_AT);
		cls_attr = kind_found_q && has_key && (attr_count_q < CNT_W'(MAX_FIELDS));
		cls_subj = kind_found_q && !has_key && (subj_count_q < CNT_W'(MAX_FIELDS));
		emit_field = closing && (len != '0) && (cls_kind || cls_attr || cls_subj);
		emit_status = (is_lf && !skipping_q) || overlong;

		desc = '0;
		desc.event_kind = EV_FIELD;
		desc.field_start = 10'(field_begin_q);
		desc.field_length = 10'(len);
		if (cls_kind) begin
			desc.field_class = CLS_KIND;
			desc.is_command = (first_byte_q >= CH_A) && (first_byte_q <= CH_Z);
		end else if (cls_attr) begin
			desc.field_class = CLS_ATTR;
			desc.field_slot = 4'(attr_count_q);
			desc.key_length = 10'(eq_offset_q);
		end else begin
			desc.field_class = CLS_SUBJECT;
			desc.field_slot = 4'(subj_count_q);
		end
		desc.last = !emit_status;

		status = '0;
		status.event_kind = EV_STATUS;
		status.last = 1'b1;
		if (overlong) begin
			status.line_status = ST_TOO_LONG;
		end else if (kind_found_q || (emit_field && cls_kind)) begin
			status.line_status = ST_OK;
		end else begin
			status.line_status = ST_NO_KIND;
		end

		push = '0;
		if (accept) begin
			if (emit_field) begin
				push.a_valid = 1'b1;
				push.a = desc;
				push.b_valid = emit_status;
				push.b = status;
			end else if (emit_status) begin
				push.a_valid = 1'b1;
				push.a = status;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_pos_q <= '0;
			field_begin_q <= '0;
			eq_offset_q <= '0;
			eq_seen_q <= 1'b0;
			first_byte_q <= '0;
			kind_found_q <= 1'b0;
			subj_count_q <= '0;
			attr_count_q <= '0;
			skipping_q <= 1'b0;
			nul_seen_q <= 1'b0;
			prev_cr_q <= 1'b0;
		end else if (accept) begin
			if (is_lf || (!skipping_q && overlong)) begin
				line_pos_q <= '0;
				field_begin_q <= '0;
				eq_offset_q <= '0;
				eq_seen_q <= 1'b0;
				first_byte_q <= '0;
				kind_found_q <= 1'b0;
				subj_count_q <= '0;
				attr_count_q <= '0;
				nul_seen_q <= 1'b0;
				prev_cr_q <= 1'b0;
				skipping_q <= !is_lf;
			end else if (!skipping_q) begin
				line_pos_q <= line_pos_q + POS_W'(1);
				if (!nul_seen_q) begin
					if (emit_field) begin
						if (cls_kind) begin
							kind_found_q <= 1'b1;
						end else if (cls_attr) begin
							attr_count_q <= attr_count_q + CNT_W'(1);
						end else begin
							subj_count_q <= subj_count_q + CNT_W'(1);
						end
					end
					if (is_nul) begin
						nul_seen_q <= 1'b1;
					end else if (is_tab) begin
						field_begin_q <= line_pos_q + POS_W'(1);
						eq_seen_q <= 1'b0;
						eq_offset_q <= '0;
						first_byte_q <= '0;
						prev_cr_q <= 1'b0;
					end else begin
						if (line_pos_q == field_begin_q) begin
							first_byte_q <= b;
						end
						if (b == CH_EQ && !eq_seen_q) begin
							eq_seen_q <= 1'b1;
							eq_offset_q <= line_pos_q - field_begin_q;
						end
						prev_cr_q <= (b == CH_CR);
					end
				end
			end
		end
	end

endmodule

@@ hw/rtl/tlft_queue.sv @@
// Result queue between front and back: two writes and one read per cycle.
module tlft_queue import tlft_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  tlft_push_t   push,
	output logic         room,
	input  logic         pop,
	output logic         head_valid,
	output tlft_result_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	tlft_result_t     mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic [PTR_W:0]   n_push;
	logic             do_pop;

	assign n_push = (PTR_W+1)'(push.a_valid) + (PTR_W+1)'(push.b_valid);
	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];
	assign do_pop = pop && head_valid;
	// Room means space for the worst case of two results from one byte.
	assign room = (count_q <= (PTR_W+1)'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + n_push - (PTR_W+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.a_valid) begin
			mem_q[wr_ptr_q] <= push.a;
		end
		if (push.b_valid) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= push.b;
		end
	end

endmodule

@@ hw/rtl/tlft_back.sv @@
// Back end: moves queued results into the output register of the token channel.
module tlft_back import tlft_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  tlft_result_t  head,
	output logic          pop,
	tlft_token_if.source  tokens
);

	logic         out_valid_q;
	tlft_result_t out_q;

	assign pop = head_valid && (!out_valid_q || tokens.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (tokens.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= head;
		end
	end

	assign tokens.valid = out_valid_q;
	assign tokens.event_kind = out_q.event_kind;
	assign tokens.field_class = out_q.field_class;
	assign tokens.field_slot = out_q.field_slot;
	assign tokens.field_start = out_q.field_start;
	assign tokens.field_length = out_q.field_length;
	assign tokens.key_length = out_q.key_length;
	assign tokens.is_command = out_q.is_command;
	assign tokens.line_status = out_q.line_status;
	assign tokens.last = out_q.last;

endmodule

@@ hw/rtl/tab_line_field_tokenizer_unit.sv @@
// Top level of the tab line field tokenizer: front end, result queue and back end.
//
// The block takes one byte of a newline-framed, tab-separated text stream per
// clock on the stream channel while the queue has room and emits field
// descriptors and one line-end status per line on the tokens channel. A byte is
// tokenized in the cycle it is accepted, so the sustained rate is one byte per
// clock while the sink keeps up; a newline that closes a field yields two items,
// which the four-entry result queue absorbs. The stream is ready whenever the
// queue holds at most two items, so input keeps flowing while a finished item
// waits in the output register. The first item of a byte goes through the queue
// into the output register, once that is free, before it is valid on tokens.
// Empty fields are dropped, leading fields that start with '@' are skipped,
// the first other field is the kind (flagged as a command when it starts with
// an uppercase letter), later fields with a '=' past their first byte are
// attributes and the rest are subjects; each class keeps at most MAX_FIELDS
// per line. A trailing CR is not counted, a NUL ends the line content, and a
// line reaching LINE_MAX_BYTES content bytes gives one too-long status after
// which bytes are discarded through the next newline.
module tab_line_field_tokenizer_unit import tlft_pkg::*; #(
	parameter int LINE_MAX_BYTES = 1024,
	parameter int MAX_FIELDS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	tlft_stream_if.sink   stream,
	tlft_token_if.source  tokens
);

	// Results of one byte travel from the front end to the queue together.
	tlft_push_t   push;
	logic         room;
	logic         pop;
	logic         head_valid;
	tlft_result_t head;

	// The front end owns all line and field state and decides per byte
	// which descriptor and which status, if any, the byte produces.
	tlft_front #(
		.LINE_MAX_BYTES(LINE_MAX_BYTES),
		.MAX_FIELDS(MAX_FIELDS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream),
		.room(room),
		.push(push)
	);

	// The queue decouples the two sides, so a stalled sink does not stop
	// the byte stream until the queue holds more than two items.
	tlft_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.pop(pop),
		.head_valid(head_valid),
		.head(head)
	);

	// The back end holds the registered output item for the sink.
	tlft_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.tokens(tokens)
	);

endmodule
